@@ src/rhsm_pkg.sv @@
package rhsm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int BYTE_W      = 8;
    localparam int HASH_W      = 32;
    localparam int CMD_W       = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic pat_shift;
        logic win_shift;
        logic active;
        logic sel_old;
    } t_cell_ctl;

endpackage

@@ src/rolling_hash_string_matcher.sv @@
// Each result passes a staging register, then the output register.
// Throughput: one item per cycle; the input stalls only while a computed
// result waits behind an output that is stalled.
// Reset: synchronous, active low; empties pattern and text state at once,
// no clearing pass. Pattern and window bytes sit in a row of cells.
module rolling_hash_string_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rhsm_pkg::CMD_W-1:0]      i_cmd,
    input  logic [rhsm_pkg::BYTE_W-1:0]     i_data_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_found,
    output logic [rhsm_pkg::HASH_W-1:0]     o_position,
    output logic [rhsm_pkg::HASH_W-1:0]     o_window_hash,
    output logic [rhsm_pkg::HASH_W-1:0]     o_pattern_hash,
    output logic                            o_pattern_overflow
);

    localparam int N  = rhsm_pkg::MAX_PATTERN;
    localparam int LW = rhsm_pkg::LEN_W;
    localparam int HW = rhsm_pkg::HASH_W;

    logic [LW-1:0] r_len,    n_len;
    logic [HW-1:0] r_ph,     n_ph;
    logic [HW-1:0] r_weight, n_weight;
    logic [HW-1:0] r_wh,     n_wh;
    logic [HW-1:0] r_cnt,    n_cnt;
    logic          r_ovf,    n_ovf;
    logic          r_s_valid, n_s_valid;
    logic          r_s_text,  n_s_text;
    logic          r_out_valid, n_out_valid;
    logic          r_found;
    logic [HW-1:0] r_pos;
    logic [HW-1:0] r_owh;
    logic [HW-1:0] r_oph;
    logic          r_oovf;

    logic          accept;
    logic          out_free;
    logic          pat_shift;
    logic          win_shift;
    logic          roll;
    logic [HW-1:0] prod;
    logic          found_c;

    rhsm_pkg::t_byte w_pat [N+1];
    rhsm_pkg::t_byte w_win [N+1];
    rhsm_pkg::t_byte w_old [N+1];
    logic            w_all [N+1];

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_s_valid && !out_free;
    assign accept   = i_valid && !o_stall;

    assign pat_shift = accept && (i_cmd == rhsm_pkg::CMD_PATTERN) && (r_len < LW'(N));
    assign win_shift = accept && (i_cmd == rhsm_pkg::CMD_TEXT);

    assign w_pat[0] = i_data_byte;
    assign w_win[0] = i_data_byte;
    assign w_old[0] = '0;
    assign w_all[0] = 1'b1;

    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_cell
            rhsm_pkg::t_cell_ctl ctl;
            assign ctl.pat_shift = pat_shift;
            assign ctl.win_shift = win_shift;
            assign ctl.active    = LW'(j) < r_len;
            assign ctl.sel_old   = LW'(j + 1) == r_len;
            rhsm_cell u_cell (
                .i_clk (i_clk),
                .i_ctl (ctl),
                .i_pat (w_pat[j]),
                .i_win (w_win[j]),
                .i_old (w_old[j]),
                .i_all (w_all[j]),
                .o_pat (w_pat[j+1]),
                .o_win (w_win[j+1]),
                .o_old (w_old[j+1]),
                .o_all (w_all[j+1])
            );
        end
    endgenerate

    assign roll = (r_len != '0) && (r_cnt >= HW'(r_len));
    assign prod = {{(HW-rhsm_pkg::BYTE_W){1'b0}}, w_old[N]} * r_weight;

    always_comb begin
        n_len    = r_len;
        n_ph     = r_ph;
        n_weight = r_weight;
        n_wh     = r_wh;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        if (accept) begin
            case (i_cmd)
                rhsm_pkg::CMD_CLEAR: begin
                    n_len    = '0;
                    n_ph     = '0;
                    n_weight = HW'(1);
                    n_wh     = '0;
                    n_cnt    = '0;
                    n_ovf    = 1'b0;
                end
                rhsm_pkg::CMD_PATTERN: begin
                    if (pat_shift) begin
                        n_len = r_len + LW'(1);
                        n_ph  = (r_ph << 1) + HW'(i_data_byte);
                        if (r_len != '0) begin
                            n_weight = r_weight << 1;
                        end
                        n_wh  = '0;
                        n_cnt = '0;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                rhsm_pkg::CMD_TEXT: begin
                    if (roll) begin
                        n_wh = ((r_wh - prod) << 1) + HW'(i_data_byte);
                    end else begin
                        n_wh = (r_wh << 1) + HW'(i_data_byte);
                    end
                    if (r_cnt != '1) begin
                        n_cnt = r_cnt + HW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_s_valid   = r_s_valid;
        n_s_text    = r_s_text;
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = r_s_valid;
            n_s_valid   = 1'b0;
        end
        if (accept) begin
            n_s_valid = 1'b1;
            n_s_text  = i_cmd == rhsm_pkg::CMD_TEXT;
        end
    end

    assign found_c = r_s_text && roll && (r_wh == r_ph) && w_all[N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ph        <= '0;
            r_weight    <= HW'(1);
            r_wh        <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_s_valid   <= 1'b0;
            r_s_text    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ph        <= n_ph;
            r_weight    <= n_weight;
            r_wh        <= n_wh;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_s_valid   <= n_s_valid;
            r_s_text    <= n_s_text;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s_valid) begin
            r_found <= found_c;
            r_pos   <= found_c ? (r_cnt - HW'(r_len)) : '0;
            r_owh   <= r_wh;
            r_oph   <= r_ph;
            r_oovf  <= r_ovf;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_found            = r_found;
    assign o_position         = r_pos;
    assign o_window_hash      = r_owh;
    assign o_pattern_hash     = r_oph;
    assign o_pattern_overflow = r_oovf;

endmodule

@@ src/rhsm_cell.sv @@
module rhsm_cell (
    input  logic                 i_clk,
    input  rhsm_pkg::t_cell_ctl  i_ctl,
    input  rhsm_pkg::t_byte      i_pat,
    input  rhsm_pkg::t_byte      i_win,
    input  rhsm_pkg::t_byte      i_old,
    input  logic                 i_all,
    output rhsm_pkg::t_byte      o_pat,
    output rhsm_pkg::t_byte      o_win,
    output rhsm_pkg::t_byte      o_old,
    output logic                 o_all
);

    rhsm_pkg::t_byte r_pat;
    rhsm_pkg::t_byte r_win;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_shift) begin
            r_pat <= i_pat;
        end
        if (i_ctl.win_shift) begin
            r_win <= i_win;
        end
    end

    assign o_pat = r_pat;
    assign o_win = r_win;
    assign o_old = i_old | (i_ctl.sel_old ? r_win : '0);
    assign o_all = i_all & (!i_ctl.active || (r_pat == r_win));

endmodule

@@ src/rhsm_checker.sv @@
module rhsm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic                            o_found,
    input  logic [rhsm_pkg::HASH_W-1:0]     o_position,
    input  logic [rhsm_pkg::HASH_W-1:0]     o_window_hash,
    input  logic [rhsm_pkg::HASH_W-1:0]     o_pattern_hash
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_position) && $stable(o_window_hash))
        else $error("stalled result changed");

    a_found_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_window_hash == o_pattern_hash)
        else $error("match reported with unequal hashes");

    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_position == '0)
        else $error("nonzero position without a match");

endmodule

bind rolling_hash_string_matcher rhsm_checker u_rhsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_found        (o_found),
    .o_position     (o_position),
    .o_window_hash  (o_window_hash),
    .o_pattern_hash (o_pattern_hash)
);

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = rhsm_pkg::CMD_W;
    localparam int HW = rhsm_pkg::HASH_W;
    localparam int NP = rhsm_pkg::MAX_PATTERN;

    localparam logic [CW-1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 1020;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [CW-1:0]   cmd;
        rhsm_pkg::t_byte data;
    } t_text_item;

    typedef struct packed {
        logic          found;
        logic [HW-1:0] position;
        logic [HW-1:0] window_hash;
        logic [HW-1:0] pattern_hash;
        logic          overflow;
    } t_match_result;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            o_stall;
    logic [CW-1:0]   in_cmd = rhsm_pkg::CMD_CLEAR;
    rhsm_pkg::t_byte in_byte = '0;
    logic            o_valid;
    logic            i_stall = 1'b0;
    logic            o_found;
    logic [HW-1:0]   o_position;
    logic [HW-1:0]   o_window_hash;
    logic [HW-1:0]   o_pattern_hash;
    logic            o_pattern_overflow;

    rolling_hash_string_matcher dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (in_valid),
        .o_stall            (o_stall),
        .i_cmd              (in_cmd),
        .i_data_byte        (in_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_found            (o_found),
        .o_position         (o_position),
        .o_window_hash      (o_window_hash),
        .o_pattern_hash     (o_pattern_hash),
        .o_pattern_overflow (o_pattern_overflow)
    );

    always #2 i_clk = ~i_clk;

    t_text_item    pending_items[$];
    t_match_result expected_results[$];
    int            total_items = 0;
    int            stim_count = 0;
    int            items_accepted = 0;
    int            error_count = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    int            idle_cycles = 0;

    rhsm_pkg::t_byte pat_mem [NP];
    rhsm_pkg::t_byte win_mem [NP];
    int unsigned     pat_len;
    int unsigned     win_wr;
    logic [HW-1:0]   pat_hash;
    logic [HW-1:0]   lead_w;
    logic [HW-1:0]   win_hash;
    logic [HW-1:0]   txt_cnt;
    logic            ovf;

    function automatic void restart_text();
        win_wr   = 0;
        win_hash = '0;
        txt_cnt  = '0;
    endfunction

    function automatic void clear_matcher();
        foreach (pat_mem[i]) pat_mem[i] = '0;
        foreach (win_mem[i]) win_mem[i] = '0;
        pat_len  = 0;
        pat_hash = '0;
        lead_w   = 32'd1;
        ovf      = 1'b0;
        restart_text();
    endfunction

    function automatic t_match_result predict_match(logic [CW-1:0] cmd, rhsm_pkg::t_byte b);
        t_match_result r;
        int unsigned   start_idx;
        bit            same;
        r = '0;
        case (cmd)
            rhsm_pkg::CMD_CLEAR: begin
                clear_matcher();
            end
            rhsm_pkg::CMD_PATTERN: begin
                if (pat_len < NP) begin
                    pat_mem[pat_len] = b;
                    pat_len++;
                    pat_hash = (pat_hash << 1) + HW'(b);
                    if (pat_len > 1) lead_w = lead_w << 1;
                    restart_text();
                end else begin
                    ovf = 1'b1;
                end
            end
            rhsm_pkg::CMD_TEXT: begin
                if (pat_len > 0 && txt_cnt >= pat_len) begin
                    start_idx = (win_wr + NP - pat_len) % NP;
                    win_hash = ((win_hash - HW'(win_mem[start_idx]) * lead_w) << 1) + HW'(b);
                end else begin
                    win_hash = (win_hash << 1) + HW'(b);
                end
                win_mem[win_wr] = b;
                win_wr = (win_wr + 1) % NP;
                if (txt_cnt != '1) txt_cnt++;
                if (pat_len > 0 && txt_cnt >= pat_len && win_hash == pat_hash) begin
                    start_idx = (win_wr + NP - pat_len) % NP;
                    same = 1'b1;
                    for (int k = 0; k < pat_len; k++)
                        if (win_mem[(start_idx + k) % NP] != pat_mem[k]) same = 1'b0;
                    if (same) begin
                        r.found    = 1'b1;
                        r.position = txt_cnt - pat_len;
                    end
                end
            end
            default: begin
            end
        endcase
        r.window_hash  = win_hash;
        r.pattern_hash = pat_hash;
        r.overflow     = ovf;
        return r;
    endfunction

    function automatic int idle_phase();
        if (total_items == 0) return 0;
        return (items_accepted * 5) / total_items;
    endfunction

    task automatic add_item(logic [CW-1:0] cmd, rhsm_pkg::t_byte b);
        t_text_item it;
        it.cmd  = cmd;
        it.data = b;
        pending_items.push_back(it);
        if (cmd != CMD_UNUSED) stim_count++;
    endtask

    task automatic check_field(string name, logic [HW-1:0] exp_v, logic [HW-1:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, got_v);
            error_count++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_text_item it;
        int         ph;
        bit         gap;
        ph = idle_phase();
        gap = (ph == 1 && $urandom_range(0, 99) < 56) || (ph == 3 && $urandom_range(0, 99) < 32);
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_stall) begin
                expected_results.push_back(predict_match(in_cmd, in_byte));
                items_accepted++;
            end
            if (!in_valid || !o_stall) begin
                if (pending_items.size() != 0 && !gap) begin
                    it = pending_items.pop_front();
                    in_valid <= 1'b1;
                    in_cmd   <= it.cmd;
                    in_byte  <= it.data;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_match_result exp_r;
        int            ph;
        ph = idle_phase();
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item pending");
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("found", HW'(exp_r.found), HW'(o_found));
                    check_field("position", exp_r.position, o_position);
                    check_field("window_hash", exp_r.window_hash, o_window_hash);
                    check_field("pattern_hash", exp_r.pattern_hash, o_pattern_hash);
                    check_field("pattern_overflow", HW'(exp_r.overflow),
                                HW'(o_pattern_overflow));
                end
            end
            if (hold_left != 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (ph == 4 && !hold_done) begin
                i_stall   <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else begin
                i_stall <= (ph == 2 && $urandom_range(0, 99) < 56)
                        || (ph == 3 && $urandom_range(0, 99) < 32);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        rhsm_pkg::t_byte pat_bytes [64];
        rhsm_pkg::t_byte a0;
        rhsm_pkg::t_byte a1;
        int              plen;
        int              tlen;
        int              n;
        bit              narrow;

        clear_matcher();

        add_item(rhsm_pkg::CMD_CLEAR, 8'h00);
        add_item(rhsm_pkg::CMD_TEXT, 8'hFF);
        add_item(rhsm_pkg::CMD_TEXT, 8'h00);
        add_item(CMD_UNUSED, 8'hAA);
        add_item(rhsm_pkg::CMD_PATTERN, 8'hFF);
        add_item(rhsm_pkg::CMD_PATTERN, 8'h00);
        add_item(rhsm_pkg::CMD_TEXT, 8'hFF);
        add_item(rhsm_pkg::CMD_TEXT, 8'h00);
        add_item(rhsm_pkg::CMD_TEXT, 8'hFF);
        add_item(rhsm_pkg::CMD_TEXT, 8'h00);
        add_item(CMD_UNUSED, 8'h55);
        add_item(rhsm_pkg::CMD_PATTERN, 8'h01);
        add_item(rhsm_pkg::CMD_TEXT, 8'hFF);
        add_item(rhsm_pkg::CMD_TEXT, 8'h00);
        add_item(rhsm_pkg::CMD_TEXT, 8'h01);
        add_item(rhsm_pkg::CMD_CLEAR, 8'hFF);
        add_item(rhsm_pkg::CMD_PATTERN, 8'h01);
        add_item(rhsm_pkg::CMD_PATTERN, 8'h00);
        add_item(rhsm_pkg::CMD_TEXT, 8'h00);
        add_item(rhsm_pkg::CMD_TEXT, 8'h02);
        add_item(rhsm_pkg::CMD_TEXT, 8'h01);
        add_item(rhsm_pkg::CMD_TEXT, 8'h00);

        while (stim_count < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 3) != 0)
                    add_item(rhsm_pkg::CMD_CLEAR, rhsm_pkg::t_byte'($urandom));
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 6);
                narrow = $urandom_range(0, 1);
                a0 = rhsm_pkg::t_byte'($urandom);
                a1 = rhsm_pkg::t_byte'($urandom);
                for (int i = 0; i < plen; i++) begin
                    pat_bytes[i] = narrow ? ($urandom_range(0, 1) ? a0 : a1)
                                          : rhsm_pkg::t_byte'($urandom);
                    add_item(rhsm_pkg::CMD_PATTERN, pat_bytes[i]);
                end
                tlen = $urandom_range(8, 40);
                for (int j = 0; j < tlen; j++) begin
                    if ($urandom_range(0, 9) < 3) begin
                        for (int k = 0; k < plen && k < NP; k++)
                            add_item(rhsm_pkg::CMD_TEXT, pat_bytes[k]);
                    end else begin
                        add_item(rhsm_pkg::CMD_TEXT,
                                 narrow ? ($urandom_range(0, 1) ? a0 : a1)
                                        : rhsm_pkg::t_byte'($urandom));
                    end
                end
            end else begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    add_item(CW'($urandom_range(0, 3)), rhsm_pkg::t_byte'($urandom));
            end
        end
        total_items = pending_items.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
